// ===== rtl/core/dhlt_pkg.sv =====
// Shared types, constants and tables of the DH link transform core.
// Used by every module under rtl/core except dhlt_checker; depends on nothing else.
package dhlt_pkg;

	// default build parameters
	localparam int DEF_NUM_JOINTS    = 6;
	localparam int DEF_FRAC_BITS     = 16;
	localparam int DEF_CORDIC_STAGES = 16;

	// fixed field widths
	localparam int JOINT_W = 3;
	localparam int ANGLE_W = 20;
	localparam int OUT_W   = 18;

	// internal widths: angle after reduction, CORDIC x and y (Q30)
	localparam int ANG_W = 33;
	localparam int CW    = 32;

	// Q30 constants
	localparam logic signed [63:0] Q30_PI      = 64'sd3373259426;
	localparam logic signed [63:0] Q30_HALF_PI = 64'sd1686629713;
	localparam logic signed [63:0] Q30_TWO_PI  = 64'sd6746518852;
	localparam logic signed [31:0] Q30_ONE     = 32'sd1073741824;
	localparam logic signed [31:0] CORDIC_GAIN = 32'sd652032874;

	// stored sine or cosine of a link twist
	typedef enum logic [1:0] {
		TW_ZERO,
		TW_POS,
		TW_NEG
	} twist_t;

	// reduced angle and sideband, reduction -> CORDIC
	typedef struct packed {
		logic [JOINT_W-1:0]      joint;
		logic                    neg;
		logic signed [ANG_W-1:0] z;
	} ang_t;

	// sine and cosine before sign fix, CORDIC -> output stage
	typedef struct packed {
		logic [JOINT_W-1:0]   joint;
		logic                 neg;
		logic signed [CW-1:0] x;
		logic signed [CW-1:0] y;
	} sc_t;

	// one result item
	typedef struct packed {
		logic signed [OUT_W-1:0] rot_00;
		logic signed [OUT_W-1:0] rot_01;
		logic signed [OUT_W-1:0] rot_02;
		logic signed [OUT_W-1:0] pos_x;
		logic signed [OUT_W-1:0] rot_10;
		logic signed [OUT_W-1:0] rot_11;
		logic signed [OUT_W-1:0] rot_12;
		logic signed [OUT_W-1:0] pos_y;
		logic signed [OUT_W-1:0] rot_21;
		logic signed [OUT_W-1:0] rot_22;
		logic signed [OUT_W-1:0] pos_z;
		logic                    bad_joint;
	} res_t;

	// arctan(2^-i), rounded to nearest Q30
	function automatic logic signed [31:0] atan_q30(input int unsigned i);
		unique case (i)
			0:  atan_q30 = 32'sd843314857;
			1:  atan_q30 = 32'sd497837829;
			2:  atan_q30 = 32'sd263043837;
			3:  atan_q30 = 32'sd133525159;
			4:  atan_q30 = 32'sd67021687;
			5:  atan_q30 = 32'sd33543516;
			6:  atan_q30 = 32'sd16775851;
			7:  atan_q30 = 32'sd8388437;
			8:  atan_q30 = 32'sd4194283;
			9:  atan_q30 = 32'sd2097149;
			10: atan_q30 = 32'sd1048576;
			11: atan_q30 = 32'sd524288;
			12: atan_q30 = 32'sd262144;
			13: atan_q30 = 32'sd131072;
			14: atan_q30 = 32'sd65536;
			15: atan_q30 = 32'sd32768;
			16: atan_q30 = 32'sd16384;
			17: atan_q30 = 32'sd8192;
			18: atan_q30 = 32'sd4096;
			19: atan_q30 = 32'sd2048;
			20: atan_q30 = 32'sd1024;
			21: atan_q30 = 32'sd512;
			22: atan_q30 = 32'sd256;
			23: atan_q30 = 32'sd128;
			24: atan_q30 = 32'sd64;
			25: atan_q30 = 32'sd32;
			26: atan_q30 = 32'sd16;
			27: atan_q30 = 32'sd8;
			28: atan_q30 = 32'sd4;
			29: atan_q30 = 32'sd2;
			default: atan_q30 = 32'sd0;
		endcase
	endfunction

	// link ROM, index = joint - 1; links past the sixth are all zero
	function automatic logic signed [31:0] link_a(input logic [JOINT_W-1:0] idx);
		unique case (idx)
			3'd1:    link_a = -32'sd456340275;
			3'd2:    link_a = -32'sd421175230;
			default: link_a = 32'sd0;
		endcase
	endfunction

	function automatic logic signed [31:0] link_d(input logic [JOINT_W-1:0] idx);
		unique case (idx)
			3'd0:    link_d = 32'sd95733747;
			3'd3:    link_d = 32'sd117198920;
			3'd4:    link_d = 32'sd101629664;
			3'd5:    link_d = 32'sd88368952;
			default: link_d = 32'sd0;
		endcase
	endfunction

	function automatic twist_t link_sa(input logic [JOINT_W-1:0] idx);
		unique case (idx)
			3'd0, 3'd3: link_sa = TW_POS;
			3'd4:       link_sa = TW_NEG;
			default:    link_sa = TW_ZERO;
		endcase
	endfunction

	function automatic twist_t link_ca(input logic [JOINT_W-1:0] idx);
		unique case (idx)
			3'd1, 3'd2, 3'd5: link_ca = TW_POS;
			default:          link_ca = TW_ZERO;
		endcase
	endfunction

	// round half up by s fraction bits, then saturate to OUT_W bits
	function automatic logic signed [OUT_W-1:0] rnd_sat(input logic signed [65:0] v,
			input int unsigned s);
		logic signed [65:0] r;
		logic signed [65:0] lim;
		lim = 66'sd1 <<< (OUT_W - 1);
		r = v;
		if (s > 0) begin
			r = (v + (66'sd1 <<< (s - 1))) >>> s;
		end
		if (r > lim - 66'sd1) begin
			r = lim - 66'sd1;
		end else if (r < -lim) begin
			r = -lim;
		end
		rnd_sat = r[OUT_W-1:0];
	endfunction

endpackage

// ===== rtl/core/dh_link_transform_core.sv =====
// Top level of the DH link transform core: stream ports, pipeline and skid
// output buffer. Depends on dhlt_pkg, dhlt_angle_reduce, dhlt_cordic, dhlt_link_out.
//
// Usage
//   Input stream s_*: one item per joint query, joint number and joint angle
//   (radians, signed, FRAC_BITS fraction bits). Output stream m_*: the eleven
//   non-constant entries of that link's DH transform in m_tdata, the bad-joint
//   flag in m_tuser. One result item for every input item, in order.
// Pipeline
//   One register stage per modulo step and per CORDIC micro-rotation. The
//   CORDIC has CORDIC_STAGES micro-rotations (at most 30 take effect); there
//   are QB = max(1, 17 - FRAC_BITS) modulo steps.
// Throughput
//   One item per cycle, sustained while the spare output register is free.
// Reset
//   arst_n clears every valid bit; the pipeline comes up empty, ready high.
// Stall
//   A stalled m_tready holds the result in the output register; the next
//   result drops into a spare register, and s_tready falls only once that
//   spare is full. Nothing is lost or repeated.
module dh_link_transform_core import dhlt_pkg::*; #(
	parameter int NUM_JOINTS    = DEF_NUM_JOINTS,
	parameter int FRAC_BITS     = DEF_FRAC_BITS,
	parameter int CORDIC_STAGES = DEF_CORDIC_STAGES
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_tvalid,
	output logic         s_tready,
	// joint_number [2:0], joint_angle [22:3], zero pad [23]
	input  logic [23:0]  s_tdata,
	output logic         m_tvalid,
	input  logic         m_tready,
	// rot_00, rot_01, rot_02, pos_x, rot_10, rot_11, rot_12, pos_y,
	// rot_21, rot_22, pos_z (18 bits each from bit 0 up), zero pad [199:198]
	output logic [199:0] m_tdata,
	// bad_joint [0]
	output logic [0:0]   m_tuser
);

	logic en;
	logic red_v;
	ang_t red_ang;
	logic cor_v;
	sc_t  cor_sc;
	logic lo_v;
	res_t lo_res;

	// whole pipeline advances while the spare register is free
	logic spare_v_q;
	res_t spare_q;
	logic out_v_q;
	res_t out_q;

	assign en       = !spare_v_q;
	assign s_tready = en;

	dhlt_angle_reduce #(
		.FRAC_BITS (FRAC_BITS)
	) u_reduce (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.in_valid  (s_tvalid),
		.joint     (s_tdata[2:0]),
		.angle     ($signed(s_tdata[22:3])),
		.out_valid (red_v),
		.out_ang   (red_ang)
	);

	dhlt_cordic #(
		.CORDIC_STAGES (CORDIC_STAGES)
	) u_cordic (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.in_valid  (red_v),
		.in_ang    (red_ang),
		.out_valid (cor_v),
		.out_sc    (cor_sc)
	);

	dhlt_link_out #(
		.NUM_JOINTS (NUM_JOINTS),
		.FRAC_BITS  (FRAC_BITS)
	) u_out (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.in_valid  (cor_v),
		.in_sc     (cor_sc),
		.out_valid (lo_v),
		.out_res   (lo_res)
	);

	// skid buffer: output register plus one spare
	logic take;
	assign take = lo_v && en;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q   <= 1'b0;
			spare_v_q <= 1'b0;
		end else if (!out_v_q || m_tready) begin
			if (spare_v_q) begin
				out_v_q   <= 1'b1;
				spare_v_q <= 1'b0;
			end else begin
				out_v_q <= take;
			end
		end else if (take) begin
			spare_v_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (!out_v_q || m_tready) begin
			out_q <= spare_v_q ? spare_q : lo_res;
		end else if (take) begin
			spare_q <= lo_res;
		end
	end

	assign m_tvalid = out_v_q;
	assign m_tdata  = {2'b00, out_q.pos_z, out_q.rot_22, out_q.rot_21, out_q.pos_y,
		out_q.rot_12, out_q.rot_11, out_q.rot_10, out_q.pos_x, out_q.rot_02,
		out_q.rot_01, out_q.rot_00};
	assign m_tuser  = out_q.bad_joint;

endmodule

// ===== rtl/core/dhlt_angle_reduce.sv =====
// Angle reduction pipeline: scales the input angle to Q30, takes it modulo
// two pi by restoring subtraction and folds it into [-pi/2, pi/2]. Uses dhlt_pkg.
module dhlt_angle_reduce import dhlt_pkg::*; #(
	parameter int FRAC_BITS = DEF_FRAC_BITS
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      en,
	input  logic                      in_valid,
	input  logic [JOINT_W-1:0]        joint,
	input  logic signed [ANGLE_W-1:0] angle,
	output logic                      out_valid,
	output ang_t                      out_ang
);

	localparam int S1 = 30 - FRAC_BITS;
	// quotient bits of |theta| / (2 pi), at least one step
	localparam int QB = (17 - FRAC_BITS > 1) ? 17 - FRAC_BITS : 1;
	// width of the Q30 magnitude
	localparam int RW = (50 - FRAC_BITS > 34) ? 50 - FRAC_BITS : 34;

	localparam logic signed [RW:0] PI_W     = (RW + 1)'(Q30_PI);
	localparam logic signed [RW:0] TWO_PI_W = (RW + 1)'(Q30_TWO_PI);
	localparam logic signed [ANG_W-1:0] PI_A   = ANG_W'(Q30_PI);
	localparam logic signed [ANG_W-1:0] HALF_A = ANG_W'(Q30_HALF_PI);

	// stage 1: Q30 magnitude and sign
	logic signed [RW:0]  th_w;
	logic [RW-1:0]       mag_in;
	logic                vld_s1;
	logic [RW-1:0]       mag_s1;
	logic                sgn_s1;
	logic [JOINT_W-1:0]  joint_s1;

	assign th_w   = (RW + 1)'(angle) <<< S1;
	assign mag_in = angle[ANGLE_W-1] ? RW'(-th_w) : RW'(th_w);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (en) begin
			vld_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			mag_s1   <= mag_in;
			sgn_s1   <= angle[ANGLE_W-1];
			joint_s1 <= joint;
		end
	end

	// stage 2: one restoring subtraction of 2 pi * 2^(QB-1-k) at step k
	logic               vld_s2   [QB];
	logic [RW-1:0]      mag_s2   [QB];
	logic               sgn_s2   [QB];
	logic [JOINT_W-1:0] joint_s2 [QB];

	for (genvar k = 0; k < QB; k++) begin : g_red
		localparam logic [RW-1:0] STEP = RW'(Q30_TWO_PI << (QB - 1 - k));
		logic               vld_p;
		logic [RW-1:0]      mag_p;
		logic               sgn_p;
		logic [JOINT_W-1:0] joint_p;

		if (k == 0) begin : g_first
			assign vld_p   = vld_s1;
			assign mag_p   = mag_s1;
			assign sgn_p   = sgn_s1;
			assign joint_p = joint_s1;
		end else begin : g_next
			assign vld_p   = vld_s2[k-1];
			assign mag_p   = mag_s2[k-1];
			assign sgn_p   = sgn_s2[k-1];
			assign joint_p = joint_s2[k-1];
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s2[k] <= 1'b0;
			end else if (en) begin
				vld_s2[k] <= vld_p;
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				mag_s2[k]   <= (mag_p >= STEP) ? mag_p - STEP : mag_p;
				sgn_s2[k]   <= sgn_p;
				joint_s2[k] <= joint_p;
			end
		end
	end

	// stage 3: restore the sign of the remainder, fold into [-pi, pi]
	logic signed [RW:0]      zr;
	logic signed [RW:0]      zf;
	logic                    vld_s3;
	logic signed [ANG_W-1:0] z_s3;
	logic [JOINT_W-1:0]      joint_s3;

	always_comb begin
		zr = sgn_s2[QB-1] ? -$signed({1'b0, mag_s2[QB-1]}) : $signed({1'b0, mag_s2[QB-1]});
		if (zr > PI_W) begin
			zf = zr - TWO_PI_W;
		end else if (zr < -PI_W) begin
			zf = zr + TWO_PI_W;
		end else begin
			zf = zr;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s3 <= 1'b0;
		end else if (en) begin
			vld_s3 <= vld_s2[QB-1];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			z_s3     <= ANG_W'(zf);
			joint_s3 <= joint_s2[QB-1];
		end
	end

	// stage 4: fold into [-pi/2, pi/2], remembering to negate sin and cos
	logic                    vld_s4;
	ang_t                    ang_s4;
	ang_t                    ang_nx;

	always_comb begin
		ang_nx.joint = joint_s3;
		if (z_s3 > HALF_A) begin
			ang_nx.z   = z_s3 - PI_A;
			ang_nx.neg = 1'b1;
		end else if (z_s3 < -HALF_A) begin
			ang_nx.z   = z_s3 + PI_A;
			ang_nx.neg = 1'b1;
		end else begin
			ang_nx.z   = z_s3;
			ang_nx.neg = 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s4 <= 1'b0;
		end else if (en) begin
			vld_s4 <= vld_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			ang_s4 <= ang_nx;
		end
	end

	assign out_valid = vld_s4;
	assign out_ang   = ang_s4;

endmodule

// ===== rtl/core/dhlt_cordic.sv =====
// Unrolled rotation-mode CORDIC, one micro-rotation per register stage.
// Uses dhlt_pkg for the arctan table, gain and stage types.
module dhlt_cordic import dhlt_pkg::*; #(
	parameter int CORDIC_STAGES = DEF_CORDIC_STAGES
) (
	input  logic clk,
	input  logic arst_n,
	input  logic en,
	input  logic in_valid,
	input  ang_t in_ang,
	output logic out_valid,
	output sc_t  out_sc
);

	// the table holds thirty angles
	localparam int N = (CORDIC_STAGES > 30) ? 30 : CORDIC_STAGES;

	logic                    vld_s   [N];
	logic signed [CW-1:0]    x_s     [N];
	logic signed [CW-1:0]    y_s     [N];
	logic signed [ANG_W-1:0] z_s     [N];
	logic [JOINT_W-1:0]      joint_s [N];
	logic                    neg_s   [N];

	for (genvar i = 0; i < N; i++) begin : g_stage
		localparam logic signed [ANG_W-1:0] ATAN = ANG_W'(atan_q30(i));
		logic                    vld_p;
		logic signed [CW-1:0]    xp;
		logic signed [CW-1:0]    yp;
		logic signed [ANG_W-1:0] zp;
		logic [JOINT_W-1:0]      joint_p;
		logic                    neg_p;
		logic                    up;

		// first stage starts from the gain on the x axis
		if (i == 0) begin : g_first
			assign vld_p   = in_valid;
			assign xp      = CORDIC_GAIN;
			assign yp      = '0;
			assign zp      = in_ang.z;
			assign joint_p = in_ang.joint;
			assign neg_p   = in_ang.neg;
		end else begin : g_next
			assign vld_p   = vld_s[i-1];
			assign xp      = x_s[i-1];
			assign yp      = y_s[i-1];
			assign zp      = z_s[i-1];
			assign joint_p = joint_s[i-1];
			assign neg_p   = neg_s[i-1];
		end

		// rotate towards zero residual angle
		assign up = !zp[ANG_W-1];

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[i] <= 1'b0;
			end else if (en) begin
				vld_s[i] <= vld_p;
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				x_s[i]     <= up ? xp - (yp >>> i) : xp + (yp >>> i);
				y_s[i]     <= up ? yp + (xp >>> i) : yp - (xp >>> i);
				z_s[i]     <= up ? zp - ATAN : zp + ATAN;
				joint_s[i] <= joint_p;
				neg_s[i]   <= neg_p;
			end
		end
	end

	assign out_valid    = vld_s[N-1];
	assign out_sc.joint = joint_s[N-1];
	assign out_sc.neg   = neg_s[N-1];
	assign out_sc.x     = x_s[N-1];
	assign out_sc.y     = y_s[N-1];

endmodule

// ===== rtl/core/dhlt_link_out.sv =====
// Output stages: link ROM lookup, products with sin and cos, then rounding
// and saturation of the eleven matrix entries. Uses dhlt_pkg.
module dhlt_link_out import dhlt_pkg::*; #(
	parameter int NUM_JOINTS = DEF_NUM_JOINTS,
	parameter int FRAC_BITS  = DEF_FRAC_BITS
) (
	input  logic clk,
	input  logic arst_n,
	input  logic en,
	input  logic in_valid,
	input  sc_t  in_sc,
	output logic out_valid,
	output res_t out_res
);

	localparam int unsigned S1 = 30 - FRAC_BITS;
	localparam int unsigned S2 = 60 - FRAC_BITS;

	// signed multiple of a value by a stored twist term
	function automatic logic signed [CW+2:0] twist_mul(input twist_t t,
			input logic signed [CW:0] v);
		unique case (t)
			TW_POS:  twist_mul = (CW + 3)'(v);
			TW_NEG:  twist_mul = -(CW + 3)'(v);
			default: twist_mul = '0;
		endcase
	endfunction

	function automatic logic signed [31:0] twist_q30(input twist_t t);
		unique case (t)
			TW_POS:  twist_q30 = Q30_ONE;
			TW_NEG:  twist_q30 = -Q30_ONE;
			default: twist_q30 = '0;
		endcase
	endfunction

	// stage 1: sign fix, ROM lookup, link-length products
	logic [JOINT_W-1:0]   idx;
	twist_t               sa;
	twist_t               ca;
	logic signed [31:0]   a_w;
	logic signed [CW:0]   sn;
	logic signed [CW:0]   cs;
	logic                 bad;

	assign idx = JOINT_W'(in_sc.joint - JOINT_W'(1));
	assign sa  = link_sa(idx);
	assign ca  = link_ca(idx);
	assign a_w = link_a(idx);
	assign sn  = in_sc.neg ? -(CW + 1)'(in_sc.y) : (CW + 1)'(in_sc.y);
	assign cs  = in_sc.neg ? -(CW + 1)'(in_sc.x) : (CW + 1)'(in_sc.x);
	assign bad = (in_sc.joint == '0) || (32'(in_sc.joint) > NUM_JOINTS);

	logic                 vld_s1;
	logic                 bad_s1;
	logic signed [CW:0]   cs_s1;
	logic signed [CW:0]   sn_s1;
	logic signed [CW+2:0] v01_s1;
	logic signed [CW+2:0] v02_s1;
	logic signed [CW+2:0] v11_s1;
	logic signed [CW+2:0] v12_s1;
	logic signed [64:0]   pax_s1;
	logic signed [64:0]   pay_s1;
	logic signed [31:0]   sa_s1;
	logic signed [31:0]   ca_s1;
	logic signed [31:0]   d_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (en) begin
			vld_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			bad_s1 <= bad;
			cs_s1  <= cs;
			sn_s1  <= sn;
			v01_s1 <= -twist_mul(ca, sn);
			v02_s1 <= twist_mul(sa, sn);
			v11_s1 <= twist_mul(ca, cs);
			v12_s1 <= -twist_mul(sa, cs);
			pax_s1 <= a_w * cs;
			pay_s1 <= a_w * sn;
			sa_s1  <= twist_q30(sa);
			ca_s1  <= twist_q30(ca);
			d_s1   <= link_d(idx);
		end
	end

	// stage 2: round and saturate; a bad joint gives zero entries
	logic vld_s2;
	res_t res_s2;
	res_t res_nx;

	always_comb begin
		if (bad_s1) begin
			res_nx           = '0;
			res_nx.bad_joint = 1'b1;
		end else begin
			res_nx.rot_00    = rnd_sat(66'(cs_s1), S1);
			res_nx.rot_01    = rnd_sat(66'(v01_s1), S1);
			res_nx.rot_02    = rnd_sat(66'(v02_s1), S1);
			res_nx.pos_x     = rnd_sat(66'(pax_s1), S2);
			res_nx.rot_10    = rnd_sat(66'(sn_s1), S1);
			res_nx.rot_11    = rnd_sat(66'(v11_s1), S1);
			res_nx.rot_12    = rnd_sat(66'(v12_s1), S1);
			res_nx.pos_y     = rnd_sat(66'(pay_s1), S2);
			res_nx.rot_21    = rnd_sat(66'(sa_s1), S1);
			res_nx.rot_22    = rnd_sat(66'(ca_s1), S1);
			res_nx.pos_z     = rnd_sat(66'(d_s1), S1);
			res_nx.bad_joint = 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s2 <= 1'b0;
		end else if (en) begin
			vld_s2 <= vld_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			res_s2 <= res_nx;
		end
	end

	assign out_valid = vld_s2;
	assign out_res   = res_s2;

endmodule

// ===== rtl/core/dhlt_checker.sv =====
// Port-level checks of the DH link transform core, bound to the top level.
// Sees the top-level ports only; no package needed.
module dhlt_checker (
	input logic         clk,
	input logic         arst_n,
	input logic         m_tvalid,
	input logic         m_tready,
	input logic [199:0] m_tdata,
	input logic [0:0]   m_tuser
);

	// output is empty once reset has been seen at a clock edge
	a_reset_empty: assert property (@(posedge clk) !arst_n |=> !m_tvalid)
		else $error("result item valid during reset");

	// a stalled result item holds
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
		else $error("stalled result item changed");

	// a bad joint gives all-zero entries
	a_bad_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser[0] |-> m_tdata[197:0] == 198'd0)
		else $error("bad joint with non-zero entries");

	// every link twist has sine or cosine zero
	a_twist: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tuser[0] |-> m_tdata[161:144] == 18'd0 || m_tdata[179:162] == 18'd0)
		else $error("twist sine and cosine both non-zero");

endmodule

bind dh_link_transform_core dhlt_checker u_dhlt_checker (.*);
